// ----- rtl/core/spq_pkg.sv -----
// Types and codes shared by the sorted priority queue and its cells.
package spq_pkg;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_REJ_FULL  = 2'd1;
  localparam logic [1:0] ST_REJ_EMPTY = 2'd2;

  typedef struct packed {
    logic [31:0] entry_time;
    logic [7:0]  start_loc;
    logic [7:0]  dest_loc;
  } entry_t;

  typedef struct packed {
    logic        func;
    logic [31:0] in_entry_time;
    logic [7:0]  in_start_loc;
    logic [7:0]  in_dest_loc;
  } in_item_t;

  typedef struct packed {
    logic        out_valid;
    logic [31:0] out_entry_time;
    logic [7:0]  out_start_loc;
    logic [7:0]  out_dest_loc;
    logic [1:0]  status;
    logic [4:0]  occupancy;
    logic        is_empty;
    logic        is_full;
  } out_item_t;

  // Broadcast from the controller to every cell in the chain.
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/sorted_priority_queue_unit.sv -----
// Sorted priority queue top level: controller, chain of cells and output register.
//
// A bounded queue of CAPACITY entries kept sorted by time in a row of cells,
// slot 0 holding the smallest time. Every cell compares its time with the
// incoming one in parallel, so an enqueue shifts the later entries one cell
// right and drops the new entry into the gap; a dequeue takes the head and
// shifts every cell one place left. Equal times leave in arrival order. One
// item is accepted per cycle while in_stall is low, and each produces one
// result in an output register; the next item is taken while that result
// waits, and in_stall rises only when the held result is stalled.
// Enqueue into a full queue and dequeue from an empty one report a reject
// status and leave the queue unchanged. No clearing pass is needed after reset.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_item_t        out_item_r;
  out_item_t        out_item_nxt;

  logic       accept;
  logic       is_full_now;
  logic       is_empty_now;
  logic       do_insert;
  logic       do_remove;
  cell_ctrl_t ctrl;

  logic   [CAPACITY-1:0] occ;
  logic   [CAPACITY-1:0] after_vec;
  entry_t [CAPACITY-1:0] entries;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign is_full_now  = (count_r == CNT_W'(CAPACITY));
  assign is_empty_now = (count_r == '0);
  assign do_insert    = accept && (in_item.func == OP_ENQUEUE) && !is_full_now;
  assign do_remove    = accept && (in_item.func == OP_DEQUEUE) && !is_empty_now;

  assign ctrl.insert               = do_insert;
  assign ctrl.remove               = do_remove;
  assign ctrl.new_entry.entry_time = in_item.in_entry_time;
  assign ctrl.new_entry.start_loc  = in_item.in_start_loc;
  assign ctrl.new_entry.dest_loc   = in_item.in_dest_loc;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   left_after;
    entry_t left_entry;
    entry_t right_entry;

    assign occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_after = 1'b0;
      assign left_entry = entries[i];
    end else begin : g_body
      assign left_after = after_vec[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ[i]),
      .left_after  (left_after),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .after       (after_vec[i]),
      .entry       (entries[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_item_nxt = '0;
    if (do_remove) begin
      out_item_nxt.out_valid      = 1'b1;
      out_item_nxt.out_entry_time = entries[0].entry_time;
      out_item_nxt.out_start_loc  = entries[0].start_loc;
      out_item_nxt.out_dest_loc   = entries[0].dest_loc;
    end
    if (in_item.func == OP_ENQUEUE && is_full_now) begin
      out_item_nxt.status = ST_REJ_FULL;
    end else if (in_item.func == OP_DEQUEUE && is_empty_now) begin
      out_item_nxt.status = ST_REJ_EMPTY;
    end else begin
      out_item_nxt.status = ST_DONE;
    end
    out_item_nxt.occupancy = 5'(count_nxt);
    out_item_nxt.is_empty  = (count_nxt == '0);
    out_item_nxt.is_full   = (count_nxt == CNT_W'(CAPACITY));
  end

  // Hold the result until taken; a new item replaces it in the same cycle.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_result_consistent : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.out_valid |->
      out_item_r.status == ST_DONE && !out_item_r.is_full)
    else $error("returned entry with inconsistent status");

  a_reject_keeps : assert property (@(posedge clk) disable iff (!rst_n)
    accept && !do_insert && !do_remove |=> $stable(count_r))
    else $error("rejected item changed the count");

endmodule

// ----- rtl/core/spq_cell.sv -----
// One slot of the sorted chain: holds an entry, shifts right on insert, left on remove.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  logic       left_after,
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  output logic       after,
  output entry_t     entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  // At or past the insert point: empty, or holding a strictly later time.
  assign after = !occupied || (entry_r.entry_time > ctrl.new_entry.entry_time);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.insert && after) begin
      entry_nxt = left_after ? left_entry : ctrl.new_entry;
    end else if (ctrl.remove) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
